// ===== hdl/wpm_pkg.sv =====
// Shared types and constants of the WAVE PCM to mono 8-bit stream block.
package wpm_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;
   localparam logic [31:0] FMT_MIN_LEN = 32'd16;

   localparam logic [1:0] KIND_FORMAT = 2'd0;
   localparam logic [1:0] KIND_SAMPLE = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [2:0] ERR_TAG       = 3'd0;
   localparam logic [2:0] ERR_SHORT_FMT = 3'd1;
   localparam logic [2:0] ERR_FORMAT    = 3'd2;
   localparam logic [2:0] ERR_NO_FRAMES = 3'd3;
   localparam logic [2:0] ERR_TRUNCATED = 3'd4;
   localparam logic [2:0] ERR_NO_FMT    = 3'd5;

   typedef enum logic [1:0] {
      OP_FORMAT = 2'd0,
      OP_ERROR  = 2'd1,
      OP_BYTE   = 2'd2
   } op_kind_type;

   // One command from the parser to the mixer.
   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  data;
      logic [2:0]  code;
      logic [31:0] rate;
      logic [31:0] frames;
      logic        is16;
      logic        stereo;
      logic        odd;
      logic        frame_end;
      logic        last;
   } op_type;

endpackage

// ===== hdl/wpm_front.sv =====
// Parser: accepts file bytes, walks the chunks and issues mixer commands.
module wpm_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [7:0]      data_byte,
   input  logic            start_of_file,
   input  logic            end_of_file,
   output logic            push,
   output wpm_pkg::op_type op
);

   typedef enum logic [7:0] {
      PH_IDLE = 8'b0000_0001,
      PH_HDR  = 8'b0000_0010,
      PH_CHDR = 8'b0000_0100,
      PH_FMT  = 8'b0000_1000,
      PH_SKIP = 8'b0001_0000,
      PH_PAD  = 8'b0010_0000,
      PH_DATA = 8'b0100_0000,
      PH_DONE = 8'b1000_0000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] bc_ff, bc_in;
   logic [31:0] cl_ff, cl_in;
   logic [31:0] tag_ff, tag_in;
   logic [15:0] fc_ff, fc_in;
   logic [1:0]  ch_ff, ch_in;
   logic [4:0]  sb_ff, sb_in;
   logic [31:0] rate_ff, rate_in;
   logic        fs_ff, fs_in;
   logic [31:0] fl_ff, fl_in;
   logic [1:0]  fbi_ff, fbi_in;

   always_comb begin
      logic [31:0] frames;
      logic        is16;
      logic        stereo;
      logic [1:0]  bpf_m1;
      logic [1:0]  frame_shift;
      phase_in = phase_ff;
      bc_in    = bc_ff;
      cl_in    = cl_ff;
      tag_in   = tag_ff;
      fc_in    = fc_ff;
      ch_in    = ch_ff;
      sb_in    = sb_ff;
      rate_in  = rate_ff;
      fs_in    = fs_ff;
      fl_in    = fl_ff;
      fbi_in   = fbi_ff;
      push     = 1'b0;
      op       = '0;
      op.kind  = wpm_pkg::OP_BYTE;
      is16     = (sb_ff == 5'd16);
      stereo   = (ch_ff == 2'd2);
      bpf_m1   = (stereo && is16) ? 2'd3 : ((stereo || is16) ? 2'd1 : 2'd0);
      // log2 of the bytes in one frame
      frame_shift = (stereo && is16) ? 2'd2 : ((stereo || is16) ? 2'd1 : 2'd0);
      frames   = '0;
      if (accept) begin
         if (start_of_file) begin
            phase_in = PH_HDR;
            bc_in = '0; cl_in = '0; tag_in = '0; fc_in = '0; ch_in = '0;
            sb_in = '0; rate_in = '0; fs_in = 1'b0; fl_in = '0; fbi_in = '0;
         end
         if (phase_in == PH_IDLE || phase_in == PH_DONE) begin
            // halt until the next file start
         end else if (end_of_file) begin
            push = 1'b1; op.kind = wpm_pkg::OP_ERROR;
            op.code = wpm_pkg::ERR_TRUNCATED; phase_in = PH_DONE;
         end else begin
            case (phase_in)
               PH_HDR: begin
                  tag_in = {tag_in[23:0], data_byte};
                  if (bc_in == 32'd3 && tag_in != wpm_pkg::TAG_RIFF) begin
                     push = 1'b1; op.kind = wpm_pkg::OP_ERROR;
                     op.code = wpm_pkg::ERR_TAG; phase_in = PH_DONE;
                  end else if (bc_in == 32'd11) begin
                     if (tag_in != wpm_pkg::TAG_WAVE) begin
                        push = 1'b1; op.kind = wpm_pkg::OP_ERROR;
                        op.code = wpm_pkg::ERR_TAG; phase_in = PH_DONE;
                     end else begin
                        bc_in = '0; phase_in = PH_CHDR;
                     end
                  end else begin
                     bc_in = bc_in + 32'd1;
                  end
               end
               PH_CHDR: begin
                  if (bc_in < 32'd4) tag_in = {tag_in[23:0], data_byte};
                  else cl_in = {data_byte, cl_in[31:8]};
                  if (bc_in == 32'd7) begin
                     bc_in = '0;
                     if (tag_in == wpm_pkg::TAG_FMT) begin
                        if (cl_in < wpm_pkg::FMT_MIN_LEN) begin
                           push = 1'b1; op.kind = wpm_pkg::OP_ERROR;
                           op.code = wpm_pkg::ERR_SHORT_FMT; phase_in = PH_DONE;
                        end else begin
                           phase_in = PH_FMT;
                        end
                     end else if (tag_in == wpm_pkg::TAG_DATA) begin
                        frames = cl_in >> frame_shift;
                        if (!fs_in) begin
                           push = 1'b1; op.kind = wpm_pkg::OP_ERROR;
                           op.code = wpm_pkg::ERR_NO_FMT; phase_in = PH_DONE;
                        end else if (fc_in != 16'd1 || ch_in == 2'd0 || sb_in == 5'd0
                                     || rate_in == 32'd0) begin
                           push = 1'b1; op.kind = wpm_pkg::OP_ERROR;
                           op.code = wpm_pkg::ERR_FORMAT; phase_in = PH_DONE;
                        end else if (frames == 32'd0) begin
                           push = 1'b1; op.kind = wpm_pkg::OP_ERROR;
                           op.code = wpm_pkg::ERR_NO_FRAMES; phase_in = PH_DONE;
                        end else begin
                           fl_in = frames; fbi_in = '0; phase_in = PH_DATA;
                           push = 1'b1; op.kind = wpm_pkg::OP_FORMAT;
                           op.rate = rate_in; op.frames = frames;
                        end
                     end else if (cl_in == 32'd0) begin
                        phase_in = cl_in[0] ? PH_PAD : PH_CHDR;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end else begin
                     bc_in = bc_in + 32'd1;
                  end
               end
               PH_FMT: begin
                  case (bc_in)
                     32'd0: fc_in = {8'd0, data_byte};
                     32'd1: fc_in = fc_in | {data_byte, 8'd0};
                     32'd2: ch_in = (data_byte == 8'd1 || data_byte == 8'd2) ?
                                    data_byte[1:0] : 2'd0;
                     32'd3: if (data_byte != 8'd0) ch_in = 2'd0;
                     32'd4, 32'd5, 32'd6, 32'd7: rate_in = {data_byte, rate_in[31:8]};
                     32'd14: sb_in = (data_byte == 8'd8 || data_byte == 8'd16) ?
                                     data_byte[4:0] : 5'd0;
                     32'd15: if (data_byte != 8'd0) sb_in = 5'd0;
                     default: ;
                  endcase
                  if (bc_in + 32'd1 == cl_in) begin
                     fs_in = 1'b1; bc_in = '0;
                     phase_in = cl_in[0] ? PH_PAD : PH_CHDR;
                  end else begin
                     bc_in = bc_in + 32'd1;
                  end
               end
               PH_SKIP: begin
                  if (bc_in + 32'd1 == cl_in) begin
                     bc_in = '0; phase_in = cl_in[0] ? PH_PAD : PH_CHDR;
                  end else begin
                     bc_in = bc_in + 32'd1;
                  end
               end
               PH_PAD: begin
                  bc_in = '0; phase_in = PH_CHDR;
               end
               PH_DATA: begin
                  push = 1'b1;
                  op.kind = wpm_pkg::OP_BYTE;
                  op.data = data_byte;
                  op.is16 = is16;
                  op.stereo = stereo;
                  op.odd = fbi_in[0];
                  if (fbi_in == bpf_m1) begin
                     op.frame_end = 1'b1;
                     fbi_in = '0;
                     fl_in = fl_in - 32'd1;
                     if (fl_in == 32'd0) begin
                        op.last = 1'b1; phase_in = PH_DONE;
                     end
                  end else begin
                     fbi_in = fbi_in + 2'd1;
                  end
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bc_ff <= '0; cl_ff <= '0; tag_ff <= '0; fc_ff <= '0; ch_ff <= '0;
         sb_ff <= '0; rate_ff <= '0; fs_ff <= 1'b0; fl_ff <= '0; fbi_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         bc_ff <= bc_in; cl_ff <= cl_in; tag_ff <= tag_in; fc_ff <= fc_in;
         ch_ff <= ch_in; sb_ff <= sb_in; rate_ff <= rate_in; fs_ff <= fs_in;
         fl_ff <= fl_in; fbi_ff <= fbi_in;
      end
   end

endmodule

// ===== hdl/wpm_queue.sv =====
// Short command queue between the parser and the mixer.
module wpm_queue #(
   parameter int unsigned DEPTH = wpm_pkg::QUEUE_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  wpm_pkg::op_type push_op,
   input  logic            pop,
   output wpm_pkg::op_type head_op,
   output logic            empty,
   output logic            full
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   wpm_pkg::op_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign empty   = (cnt_ff == '0);
   assign full    = (cnt_ff == CW'(DEPTH));
   assign head_op = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      if (pop)  rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      if (push && !pop) cnt_in = cnt_ff + CW'(1);
      if (pop && !push) cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_op;
   end

endmodule

// ===== hdl/wpm_back.sv =====
// Mixer: carries out parser commands and holds the result register.
module wpm_back (
   input  logic            clock,
   input  logic            reset,
   input  logic            have_op,
   input  wpm_pkg::op_type op,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [1:0]      kind,
   output logic [7:0]      sample,
   output logic [31:0]     rate,
   output logic [31:0]     frames,
   output logic [2:0]      code,
   output logic            last
);

   logic               valid_ff, valid_in;
   logic signed [17:0] sum_ff, sum_in;
   logic [7:0]         low_ff, low_in;
   logic [1:0]         kind_ff, kind_in;
   logic [7:0]         smp_ff, smp_in;
   logic [31:0]        rate_ff, rate_in, frm_ff, frm_in;
   logic [2:0]         code_ff, code_in;
   logic               last_ff, last_in;
   logic               produces;

   assign produces = (op.kind != wpm_pkg::OP_BYTE) || op.frame_end;
   assign pop = have_op && (!produces || !valid_ff || rsp_ready);

   always_comb begin
      logic signed [17:0] contrib, acc, half, v;
      contrib = op.is16 ? 18'(signed'({op.data, low_ff}))
                        : 18'(signed'(op.data ^ 8'h80));
      acc  = sum_ff + contrib;
      half = (acc + $signed({17'd0, acc[17]})) >>> 1;
      v    = op.stereo ? half : acc;
      valid_in = valid_ff;
      sum_in = sum_ff; low_in = low_ff;
      kind_in = kind_ff; smp_in = smp_ff; rate_in = rate_ff; frm_in = frm_ff;
      code_in = code_ff; last_in = last_ff;
      if (valid_ff && rsp_ready) valid_in = 1'b0;
      if (pop) begin
         case (op.kind)
            wpm_pkg::OP_FORMAT: begin
               sum_in = '0; valid_in = 1'b1;
               kind_in = wpm_pkg::KIND_FORMAT; smp_in = '0; rate_in = op.rate;
               frm_in = op.frames; code_in = '0; last_in = 1'b0;
            end
            wpm_pkg::OP_ERROR: begin
               valid_in = 1'b1;
               kind_in = wpm_pkg::KIND_ERROR; smp_in = '0; rate_in = '0;
               frm_in = '0; code_in = op.code; last_in = 1'b0;
            end
            default: begin
               if (op.is16 && !op.odd) begin
                  low_in = op.data;
               end else if (op.frame_end) begin
                  sum_in = '0; valid_in = 1'b1;
                  kind_in = wpm_pkg::KIND_SAMPLE;
                  smp_in = op.is16 ? (v[15:8] ^ 8'h80) : (v[7:0] ^ 8'h80);
                  rate_in = '0; frm_in = '0; code_in = '0; last_in = op.last;
               end else begin
                  sum_in = acc;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0; sum_ff <= '0; low_ff <= '0;
      end else begin
         valid_ff <= valid_in; sum_ff <= sum_in; low_ff <= low_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in; smp_ff <= smp_in; rate_ff <= rate_in;
      frm_ff <= frm_in; code_ff <= code_in; last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign kind = kind_ff;
   assign sample = smp_ff;
   assign rate = rate_ff;
   assign frames = frm_ff;
   assign code = code_ff;
   assign last = last_ff;

endmodule

// ===== hdl/wav_pcm_to_mono8_stream.sv =====
// Top level of the WAVE PCM to mono 8-bit stream block.
//
//   channel   direction   payload
//   req_*     in          tdata data_byte, tuser start_of_file, tlast end_of_file
//   rsp_*     out         tdata sample/rate/frames/error, tuser kind, tlast last
//
// One byte is taken per clock while req_tready is high; the parser finishes a byte
// in the cycle it is taken and the mixer drains one queued command per clock unless
// a held result stalls it; results pass the queue, then the result register.
// Reset is synchronous, active high, and leaves the block waiting for a file start.
// A stalled response fills the command queue; req_tready drops only when it is full.
module wav_pcm_to_mono8_stream #(
   parameter int unsigned QUEUE_DEPTH = wpm_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] start_of_file
   input  logic        req_tlast,   // end_of_file
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [7:0] mono_sample, [39:8] rate_hz,
                                    // [71:40] frame_total, [74:72] error_code
   output logic [1:0]  rsp_tuser,   // [1:0] result_kind
   output logic        rsp_tlast    // last_sample
);

   logic            accept, push, pop, empty, full;
   wpm_pkg::op_type push_op, head_op;
   logic [1:0]      kind;
   logic [7:0]      sample;
   logic [31:0]     rate, frames;
   logic [2:0]      code;

   assign req_tready = !full;
   assign accept = req_tvalid && req_tready;

   wpm_front u_front (
      .clock, .reset, .accept,
      .data_byte(req_tdata), .start_of_file(req_tuser), .end_of_file(req_tlast),
      .push, .op(push_op)
   );

   wpm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset, .push, .push_op, .pop, .head_op, .empty, .full
   );

   wpm_back u_back (
      .clock, .reset, .have_op(!empty), .op(head_op), .pop,
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .kind, .sample, .rate, .frames, .code, .last(rsp_tlast)
   );

   // Pack the response fields, lowest first, padded to whole bytes.
   assign rsp_tdata = {5'd0, code, frames, rate, sample};
   assign rsp_tuser = kind;

endmodule

// ===== hdl/wpm_checker.sv =====
// Port-level checker for the WAVE PCM to mono 8-bit stream block.
module wpm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == wpm_pkg::KIND_FORMAT ||
                      rsp_tuser == wpm_pkg::KIND_SAMPLE ||
                      rsp_tuser == wpm_pkg::KIND_ERROR))
      else $error("bad result kind");

   a_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser == wpm_pkg::KIND_SAMPLE)
      else $error("last flag on non-sample");

   a_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == wpm_pkg::KIND_ERROR) |-> rsp_tdata[71:0] == '0)
      else $error("error carries payload");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind wav_pcm_to_mono8_stream wpm_checker u_wpm_checker (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast
);

// ===== dv/tb_wav_pcm_to_mono8_stream.sv =====
// Self-checking testbench for the WAVE PCM to mono 8-bit stream block.
`timescale 1ns / 100ps

module tb_wav_pcm_to_mono8_stream;

   typedef struct packed {
      logic [7:0] data;
      logic       sof;
      logic       eof;
   } request_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  smp;
      logic [31:0] rate;
      logic [31:0] frames;
      logic [2:0]  code;
      logic        last;
   } result_type;

   typedef enum logic [3:0] {
      PH_IDLE, PH_HDR, PH_CHDR, PH_FMT, PH_SKIP, PH_PAD, PH_DATA, PH_DONE
   } phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] data_byte
   logic        req_tuser = 1'b0;   // [0] start_of_file
   logic        req_tlast = 1'b0;   // end_of_file
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;          // [7:0] mono_sample, [39:8] rate_hz,
                                    // [71:40] frame_total, [74:72] error_code
   logic [1:0]  rsp_tuser;          // [1:0] result_kind
   logic        rsp_tlast;          // last_sample

   wav_pcm_to_mono8_stream u_top (.*);

   request_type pending_requests[$];
   result_type  expected_results[$];
   logic [7:0]  file_bytes[$];
   int          error_count = 0;
   int          requests_taken = 0;
   int          file_requests = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Parser/mixer predictor: own copy of the parse state.
   // ---------------------------------------------------------------------
   phase_type   phase;
   logic [31:0] byte_idx, chunk_len, tag_reg, rate_reg, frames_to_go;
   logic [15:0] fmt_code;
   logic [1:0]  chans;
   logic [4:0]  bits;
   logic        fmt_known;
   logic [1:0]  frame_idx;
   logic [7:0]  low_hold;
   int          mix_acc;

   task automatic clear_parse();
      phase = PH_IDLE; byte_idx = 0; chunk_len = 0; tag_reg = 0; rate_reg = 0;
      frames_to_go = 0; fmt_code = 0; chans = 0; bits = 0; fmt_known = 0;
      frame_idx = 0; low_hold = 0; mix_acc = 0;
   endtask

   task automatic push_result(logic [1:0] kind, logic [7:0] smp, logic [31:0] rate,
                              logic [31:0] frames, logic [2:0] code, logic last);
      result_type r;
      r.kind = kind; r.smp = smp; r.rate = rate; r.frames = frames;
      r.code = code; r.last = last;
      expected_results.push_back(r);
   endtask

   task automatic abort_file(logic [2:0] code);
      phase = PH_DONE;
      push_result(wpm_pkg::KIND_ERROR, 8'd0, 32'd0, 32'd0, code, 1'b0);
   endtask

   task automatic end_of_chunk();
      byte_idx = 0;
      phase = chunk_len[0] ? PH_PAD : PH_CHDR;
   endtask

   task automatic close_chunk_header();
      logic [31:0] frame_bytes;
      logic [31:0] frames;
      byte_idx = 0;
      if (tag_reg == wpm_pkg::TAG_FMT) begin
         if (chunk_len < wpm_pkg::FMT_MIN_LEN) abort_file(wpm_pkg::ERR_SHORT_FMT);
         else phase = PH_FMT;
      end else if (tag_reg == wpm_pkg::TAG_DATA) begin
         if (!fmt_known) abort_file(wpm_pkg::ERR_NO_FMT);
         else if (fmt_code != 16'd1 || chans == 0 || bits == 0 || rate_reg == 0)
            abort_file(wpm_pkg::ERR_FORMAT);
         else begin
            frame_bytes = chans * (bits / 8);
            frames = chunk_len / frame_bytes;
            if (frames == 0) abort_file(wpm_pkg::ERR_NO_FRAMES);
            else begin
               frames_to_go = frames; frame_idx = 0; mix_acc = 0; phase = PH_DATA;
               push_result(wpm_pkg::KIND_FORMAT, 8'd0, rate_reg, frames, 3'd0, 1'b0);
            end
         end
      end else if (chunk_len == 0) end_of_chunk();
      else phase = PH_SKIP;
   endtask

   task automatic mix_byte(logic [7:0] b);
      int frame_bytes;
      int v;
      frame_bytes = chans * (bits / 8);
      if (bits == 5'd8) mix_acc += int'(b) - 128;
      else if (!frame_idx[0]) low_hold = b;
      else mix_acc += int'(signed'({b, low_hold}));
      if (frame_idx + 1 < frame_bytes) begin
         frame_idx = frame_idx + 2'd1;
         return;
      end
      v = mix_acc / int'(chans);
      if (bits == 5'd8) v = v + 128;
      else v = (v + 32768) >>> 8;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      frame_idx = 0; mix_acc = 0; frames_to_go = frames_to_go - 1;
      if (frames_to_go == 0) phase = PH_DONE;
      push_result(wpm_pkg::KIND_SAMPLE, v[7:0], 32'd0, 32'd0, 3'd0, frames_to_go == 0);
   endtask

   task automatic predict_request(request_type q);
      if (q.sof) begin
         clear_parse();
         phase = PH_HDR;
      end
      if (phase == PH_IDLE || phase == PH_DONE) return;
      if (q.eof) begin
         abort_file(wpm_pkg::ERR_TRUNCATED);
         return;
      end
      case (phase)
         PH_HDR: begin
            tag_reg = {tag_reg[23:0], q.data};
            if (byte_idx == 3 && tag_reg != wpm_pkg::TAG_RIFF) abort_file(wpm_pkg::ERR_TAG);
            else if (byte_idx == 11) begin
               if (tag_reg != wpm_pkg::TAG_WAVE) abort_file(wpm_pkg::ERR_TAG);
               else begin byte_idx = 0; phase = PH_CHDR; end
            end else byte_idx++;
         end
         PH_CHDR: begin
            if (byte_idx < 4) tag_reg = {tag_reg[23:0], q.data};
            else chunk_len = {q.data, chunk_len[31:8]};
            if (byte_idx == 7) close_chunk_header();
            else byte_idx++;
         end
         PH_FMT: begin
            case (byte_idx)
               0: fmt_code = {8'd0, q.data};
               1: fmt_code[15:8] = q.data;
               2: chans = (q.data == 1 || q.data == 2) ? q.data[1:0] : 2'd0;
               3: if (q.data != 0) chans = 0;
               4, 5, 6, 7: rate_reg = {q.data, rate_reg[31:8]};
               14: bits = (q.data == 8 || q.data == 16) ? q.data[4:0] : 5'd0;
               15: if (q.data != 0) bits = 0;
               default: ;
            endcase
            if (byte_idx + 1 == chunk_len) begin
               fmt_known = 1;
               end_of_chunk();
            end else byte_idx++;
         end
         PH_SKIP: begin
            if (byte_idx + 1 == chunk_len) end_of_chunk();
            else byte_idx++;
         end
         PH_PAD: begin
            byte_idx = 0;
            phase = PH_CHDR;
         end
         PH_DATA: mix_byte(q.data);
         default: phase = PH_IDLE;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // File builder: assemble a file in file_bytes, then queue it.
   // ---------------------------------------------------------------------
   task automatic put_le(logic [31:0] v, int n);
      for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
   endtask

   task automatic put_tag(logic [31:0] t);
      for (int i = 3; i >= 0; i--) file_bytes.push_back(t[8*i +: 8]);
   endtask

   task automatic put_fmt(int code, int ch, int rate, int nbits, int flen);
      put_tag(wpm_pkg::TAG_FMT); put_le(flen, 4);
      put_le(code, 2); put_le(ch, 2); put_le(rate, 4);
      put_le(rate * ch * nbits / 8, 4); put_le(ch * nbits / 8, 2); put_le(nbits, 2);
      for (int i = 16; i < flen; i++) file_bytes.push_back($urandom_range(0, 255));
      if (flen < 16) repeat (16 - flen) void'(file_bytes.pop_back());
      if (flen % 2) file_bytes.push_back(8'h00);
   endtask

   // fill: 0 random, 1 all zero, 2 all ones, 3 16-bit full-scale swings
   task automatic build_wav(int code, int ch, int rate, int nbits, int flen, int dlen,
                            int junk_len, bit fmt_twice, bit fmt_after, int fill);
      file_bytes.delete();
      put_tag(wpm_pkg::TAG_RIFF); put_le($urandom, 4); put_tag(wpm_pkg::TAG_WAVE);
      if (junk_len >= 0) begin
         put_tag(32'h4C49_5354); put_le(junk_len, 4);
         for (int i = 0; i < junk_len + junk_len % 2; i++)
            file_bytes.push_back($urandom_range(0, 255));
      end
      if (fmt_twice) put_fmt(3, 4, 0, 24, 16);
      if (!fmt_after) put_fmt(code, ch, rate, nbits, flen);
      put_tag(wpm_pkg::TAG_DATA); put_le(dlen, 4);
      for (int i = 0; i < dlen; i++)
         case (fill)
            1: file_bytes.push_back(8'h00);
            2: file_bytes.push_back(8'hFF);
            3: file_bytes.push_back((i % 4 == 0) ? 8'h00 : (i % 4 == 1) ? 8'h80 :
                                    (i % 4 == 2) ? 8'hFF : 8'h7F);
            default: file_bytes.push_back($urandom_range(0, 255));
         endcase
      if (fmt_after) put_fmt(code, ch, rate, nbits, flen);
   endtask

   task automatic queue_request(logic [7:0] d, logic sof, logic eof);
      request_type q;
      q.data = d; q.sof = sof; q.eof = eof;
      pending_requests.push_back(q);
      file_requests++;
   endtask

   // Queue the built file, cut after keep bytes (negative keeps all), then
   // optionally close with end_of_file.
   task automatic queue_file(int keep, bit close);
      int n;
      n = (keep < 0 || keep > file_bytes.size()) ? file_bytes.size() : keep;
      for (int i = 0; i < n; i++) queue_request(file_bytes[i], i == 0, 1'b0);
      if (close) queue_request($urandom_range(0, 255), n == 0, 1'b1);
   endtask

   task automatic random_file();
      int pick, ch, nbits, code, rate, flen, dlen;
      pick = $urandom_range(0, 99);
      ch = $urandom_range(1, 2);
      nbits = $urandom_range(0, 1) ? 16 : 8;
      code = 1;
      rate = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(8000, 96000);
      flen = ($urandom_range(0, 5) == 0) ? 18 : 16;
      dlen = $urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : $urandom_range(4, 60);
      if (pick >= 85 && pick < 92) case ($urandom_range(0, 4))
         0: code = $urandom_range(2, 65535);
         1: ch = $urandom_range(0, 1) ? 0 : $urandom_range(3, 255);
         2: nbits = $urandom_range(0, 40);
         3: rate = 0;
         default: flen = $urandom_range(0, 15);
      endcase
      build_wav(code, ch, rate, nbits, flen, dlen,
                $urandom_range(0, 3) == 0 ? $urandom_range(0, 9) : -1,
                $urandom_range(0, 7) == 0, pick >= 92 && pick < 95, 0);
      if (pick >= 75 && pick < 85)
         file_bytes[$urandom_range(0, file_bytes.size() - 1)] ^= 8'd1 << $urandom_range(0, 7);
      if (pick >= 95) queue_file($urandom_range(0, file_bytes.size()), $urandom_range(0, 1));
      else queue_file(-1, $urandom_range(0, 2) == 0);
      // stray bytes after the file: ignored once the run has halted
      repeat ($urandom_range(0, 2)) begin
         queue_request($urandom_range(0, 255), 1'b0, $urandom_range(0, 1));
         file_requests--;
      end
   endtask

   // ---------------------------------------------------------------------
   // Sender: bursts of random length with random gaps.
   // ---------------------------------------------------------------------
   request_type on_wire;
   int          burst_left = 0;
   int          gap_left = 0;

   always @(posedge clock) begin
      bit held;
      bit next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         held = req_tvalid;
         if (req_tvalid && req_tready) begin
            predict_request(on_wire);
            requests_taken++;
            held = 0;
         end
         if (!held) begin
            next_valid = 0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_requests.size() > 0) begin
               on_wire = pending_requests.pop_front();
               next_valid = 1;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
            req_tvalid <= next_valid;
            req_tdata  <= on_wire.data;
            req_tuser  <= on_wire.sof;
            req_tlast  <= on_wire.eof;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random choice among three stall patterns; one long hold-off.
   // ---------------------------------------------------------------------
   int  stall_mode = 0;
   int  mode_cycles = 0;
   int  holdoff_left = 0;
   bit  holdoff_done = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (!holdoff_done && requests_taken >= 600) begin
            holdoff_done = 1;
            holdoff_left = 400;
         end
         if (++mode_cycles == 150) begin
            mode_cycles = 0;
            stall_mode = $urandom_range(0, 2);
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_tready <= 1'b0;
         end else case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= $urandom_range(0, 1);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Result check against the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result: kind %0d data %h", rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tuser !== want.kind) begin
               $error("result_kind: expected %0d, got %0d", want.kind, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[7:0] !== want.smp) begin
               $error("mono_sample: expected %0d, got %0d", want.smp, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tdata[39:8] !== want.rate) begin
               $error("rate_hz: expected %0d, got %0d", want.rate, rsp_tdata[39:8]);
               error_count++;
            end
            if (rsp_tdata[71:40] !== want.frames) begin
               $error("frame_total: expected %0d, got %0d", want.frames, rsp_tdata[71:40]);
               error_count++;
            end
            if (rsp_tdata[74:72] !== want.code) begin
               $error("error_code: expected %0d, got %0d", want.code, rsp_tdata[74:72]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_sample: expected %0d, got %0d", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run if nothing moves for too long.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= 3000) begin
         $display("tb_wav_pcm_to_mono8_stream: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run.
   // ---------------------------------------------------------------------
   initial begin
      clear_parse();
      // idle bytes and end_of_file before any file start
      queue_request(8'hFF, 1'b0, 1'b0);
      queue_request(8'h00, 1'b0, 1'b1);
      // empty file: start and end together
      queue_request(8'h52, 1'b1, 1'b1);
      // mono and stereo 8-bit, all-zero and all-ones samples, junk chunk of odd length
      build_wav(1, 1, 8000, 8, 16, 3, 3, 0, 0, 1); queue_file(-1, 1);
      build_wav(1, 2, 44100, 8, 18, 4, -1, 0, 0, 2); queue_file(-1, 0);
      // 16-bit full-scale swings, mono and stereo, odd data length
      build_wav(1, 1, 48000, 16, 16, 8, -1, 0, 0, 3); queue_file(-1, 0);
      build_wav(1, 2, 32'hFFFF_FFFF, 16, 16, 9, 0, 1, 0, 3); queue_file(-1, 0);
      // bad RIFF tag, bad WAVE tag
      build_wav(1, 1, 8000, 8, 16, 2, -1, 0, 0, 0);
      file_bytes[3] = 8'h58; queue_file(-1, 0);
      build_wav(1, 1, 8000, 8, 16, 2, -1, 0, 0, 0);
      file_bytes[11] = 8'h58; queue_file(-1, 0);
      // short fmt, data before fmt, unsupported format, no frames
      build_wav(1, 1, 8000, 8, 14, 2, -1, 0, 0, 0); queue_file(-1, 0);
      build_wav(1, 1, 8000, 8, 16, 2, -1, 0, 1, 0); queue_file(-1, 0);
      build_wav(3, 1, 8000, 8, 16, 2, -1, 0, 0, 0); queue_file(-1, 0);
      build_wav(1, 2, 8000, 16, 16, 3, -1, 0, 0, 0); queue_file(-1, 0);
      // truncated in the data, then restart mid-file without a close
      build_wav(1, 2, 22050, 8, 16, 10, -1, 0, 0, 0); queue_file(50, 1);
      build_wav(1, 1, 22050, 8, 16, 10, -1, 0, 0, 0); queue_file(30, 0);

      while (file_requests < 1700) random_file();

      wait (!reset);
      wait (pending_requests.size() == 0 && !req_tvalid);
      wait (expected_results.size() == 0);
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0)
         $display("tb_wav_pcm_to_mono8_stream: clean");
      else
         $display("tb_wav_pcm_to_mono8_stream: errors");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

endmodule

// ===== files.f =====
hdl/wpm_pkg.sv
hdl/wpm_front.sv
hdl/wpm_queue.sv
hdl/wpm_back.sv
hdl/wav_pcm_to_mono8_stream.sv
hdl/wpm_checker.sv
dv/tb_wav_pcm_to_mono8_stream.sv
